// ----- rtl/core/planar_distance_and_bearing_core_defines.svh -----
// Assertion macros shared by the core.
`ifndef PLANAR_DISTANCE_AND_BEARING_CORE_DEFINES_SVH
`define PLANAR_DISTANCE_AND_BEARING_CORE_DEFINES_SVH

// Same-cycle implication.
`define PDB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdb assertion failed");

// Next-cycle implication.
`define PDB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdb assertion failed");

`endif

// ----- rtl/core/pdb_pkg.sv -----
package pdb_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STAGES   = 24;

	localparam int DIST_WIDTH  = COORD_WIDTH + 1;
	localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 9;
	localparam int PHI_WIDTH   = ANGLE_FRAC_BITS + 6;

	localparam logic [63:0] QT_HALF         = 64'h2000_0000_0000_0000;
	localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_1529;

	typedef struct packed {
		logic sx;
		logic sy;
		logic zx;
		logic zy;
		logic swap;
	} flg_t;

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] atan_entry(input int idx);
		logic [63:0]  s;
		logic [63:0]  term;
		logic [127:0] prod;
		logic         done;
		int           e;
		s    = '0;
		done = 1'b0;
		if (idx == 0) begin
			return QT_HALF;
		end
		for (int k = 0; k < 64; k++) begin
			e = idx * (2 * k + 1);
			if (!done && e > 62) begin
				done = 1'b1;
			end
			if (!done) begin
				term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
				if (term == 64'd0) begin
					done = 1'b1;
				end else if (k % 2 == 1) begin
					s = s - term;
				end else begin
					s = s + term;
				end
			end
		end
		prod = 128'(s) * 128'(TWO_OVER_PI_Q64);
		return prod[127:64];
	endfunction

endpackage

// ----- rtl/core/planar_distance_and_bearing_core.sv -----
// Planar distance and bearing between two points.
// Input stream s_*: one transaction carries first_x, first_y, second_x,
// second_y as signed coordinates. Output stream m_*: one transaction per
// input carries the floor Euclidean distance and the direction of
// (first - second) in degrees with 16 fraction bits; m_tuser flags
// coincident points (angle and distance then read 0).
// The depth from input acceptance to m_tvalid is set by the
// bit-per-stage square root (33 stages after the squaring and sum).
// The angle path (octant normalize, 24 CORDIC stages, scaling and
// quadrant mapping) finishes earlier and is delayed to line up.
// Throughput: one transaction per cycle; the pipeline advances whenever
// the output register is empty or being taken.
// Reset clears all stage valid bits; no output is presented until new
// input arrives. When m_tready stays low with a result waiting, the
// whole pipeline and s_tready hold, and nothing is lost or repeated.
module planar_distance_and_bearing_core
	import pdb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// first_x, first_y, second_x, second_y
	input  logic [4*COORD_WIDTH-1:0] s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// distance, angle_deg, zero fill
	output logic [((DIST_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata,
	// coincident
	output logic [0:0]    m_tuser
);

	localparam int D      = DIST_WIDTH;
	localparam int N      = 2 * D;
	localparam int F      = ANGLE_FRAC_BITS;
	localparam int OUT_W  = ((DIST_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
	localparam int S_SQ0  = 4;
	localparam int S_OUT  = S_SQ0 + D;
	localparam int S_C0   = 6;
	localparam int S_CL   = S_C0 + CORDIC_STAGES;
	localparam int S_PHI  = S_CL + 1;
	localparam int S_ANG  = S_CL + 2;

	localparam logic [ANGLE_WIDTH-1:0] DEG90  = ANGLE_WIDTH'(90)  << F;
	localparam logic [ANGLE_WIDTH-1:0] DEG180 = ANGLE_WIDTH'(180) << F;
	localparam logic [ANGLE_WIDTH-1:0] DEG270 = ANGLE_WIDTH'(270) << F;
	localparam logic [ANGLE_WIDTH-1:0] DEG360 = ANGLE_WIDTH'(360) << F;
	localparam logic [63:0] RND = 64'd1 << (55 - F);

	logic en;
	logic [S_OUT:1] vld_s;

	logic signed [D-1:0] dx_s1, dy_s1;
	logic [D-1:0] ax_s2, ay_s2;
	logic [N-1:0] sqx_s3, sqy_s3;
	logic [D-1:0] oa_s3, ob_s3;
	logic [63:0] na_s4, nb_s4, na_s5, nb_s5;
	flg_t flg_s [2:S_OUT];

	logic [N-1:0] rad_s  [S_SQ0:S_OUT];
	logic [D:0]   rem_s  [S_SQ0:S_OUT];
	logic [D-1:0] root_s [S_SQ0:S_OUT];

	logic [63:0] cx_s [S_C0:S_CL];
	logic [63:0] cy_s [S_C0:S_CL];
	logic [63:0] cz_s [S_C0:S_CL];

	logic [PHI_WIDTH-1:0]   phi_s31;
	logic [ANGLE_WIDTH-1:0] ang_s [S_ANG:S_OUT];

	logic [63:0] a4, b4, a5, b5, a6, b6;
	logic [63:0] zc, zs, zv;
	logic [ANGLE_WIDTH-1:0] pfe, ang_n;
	logic signed [D-1:0] dxn, dyn;

	assign en       = !vld_s[S_OUT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[S_OUT];
	assign m_tdata  = OUT_W'({ang_s[S_OUT], root_s[S_OUT]});
	assign m_tuser  = flg_s[S_OUT].zx && flg_s[S_OUT].zy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[S_OUT-1:1], s_tvalid};
		end
	end

	always_comb begin
		dxn = D'($signed(s_tdata[0 +: COORD_WIDTH])) -
			D'($signed(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
		dyn = D'($signed(s_tdata[COORD_WIDTH +: COORD_WIDTH])) -
			D'($signed(s_tdata[3*COORD_WIDTH +: COORD_WIDTH]));

		a4 = 64'(oa_s3);
		b4 = 64'(ob_s3);
		if (a4[59:28] == '0) begin
			a4 = a4 << 32;
			b4 = b4 << 32;
		end
		if (a4[59:44] == '0) begin
			a4 = a4 << 16;
			b4 = b4 << 16;
		end
		a5 = na_s4;
		b5 = nb_s4;
		if (a5[59:52] == '0) begin
			a5 = a5 << 8;
			b5 = b5 << 8;
		end
		if (a5[59:56] == '0) begin
			a5 = a5 << 4;
			b5 = b5 << 4;
		end
		a6 = na_s5;
		b6 = nb_s5;
		if (a6[59:58] == '0) begin
			a6 = a6 << 2;
			b6 = b6 << 2;
		end
		if (!a6[59]) begin
			a6 = a6 << 1;
			b6 = b6 << 1;
		end

		if (cz_s[S_CL][63]) begin
			zc = '0;
		end else if (cz_s[S_CL] > QT_HALF) begin
			zc = QT_HALF;
		end else begin
			zc = cz_s[S_CL];
		end
		zs = zc >> 6;
		zv = (zs << 6) + (zs << 4) + (zs << 3) + (zs << 1) + RND;

		pfe = flg_s[S_PHI].swap ? DEG90 - ANGLE_WIDTH'(phi_s31) : ANGLE_WIDTH'(phi_s31);
		priority if (flg_s[S_PHI].zx && flg_s[S_PHI].zy) begin
			ang_n = '0;
		end else if (flg_s[S_PHI].zy) begin
			ang_n = flg_s[S_PHI].sx ? DEG180 : '0;
		end else if (flg_s[S_PHI].zx) begin
			ang_n = flg_s[S_PHI].sy ? DEG270 : DEG90;
		end else if (!flg_s[S_PHI].sx && !flg_s[S_PHI].sy) begin
			ang_n = pfe;
		end else if (flg_s[S_PHI].sx && !flg_s[S_PHI].sy) begin
			ang_n = DEG180 - pfe;
		end else if (flg_s[S_PHI].sx) begin
			ang_n = DEG180 + pfe;
		end else begin
			ang_n = DEG360 - pfe;
		end
		if (ang_n >= DEG360) begin
			ang_n = ang_n - DEG360;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dxn;
			dy_s1 <= dyn;

			ax_s2 <= dx_s1[D-1] ? D'(-dx_s1) : D'(dx_s1);
			ay_s2 <= dy_s1[D-1] ? D'(-dy_s1) : D'(dy_s1);
			flg_s[2] <= '{sx: dx_s1[D-1], sy: dy_s1[D-1],
				zx: dx_s1 == '0, zy: dy_s1 == '0, swap: 1'b0};

			flg_s[3] <= '{sx: flg_s[2].sx, sy: flg_s[2].sy,
				zx: flg_s[2].zx, zy: flg_s[2].zy, swap: ay_s2 > ax_s2};
			for (int k = 3; k < S_OUT; k++) begin
				flg_s[k+1] <= flg_s[k];
			end

			sqx_s3 <= N'(ax_s2) * N'(ax_s2);
			sqy_s3 <= N'(ay_s2) * N'(ay_s2);
			oa_s3  <= (ay_s2 > ax_s2) ? ay_s2 : ax_s2;
			ob_s3  <= (ay_s2 > ax_s2) ? ax_s2 : ay_s2;

			rad_s[S_SQ0]  <= sqx_s3 + sqy_s3;
			rem_s[S_SQ0]  <= '0;
			root_s[S_SQ0] <= '0;
			na_s4 <= a4;
			nb_s4 <= b4;

			na_s5 <= a5;
			nb_s5 <= b5;

			cx_s[S_C0] <= a6;
			cy_s[S_C0] <= b6;
			cz_s[S_C0] <= '0;

			phi_s31 <= zv[56-F +: PHI_WIDTH];

			ang_s[S_ANG] <= ang_n;
			for (int k = S_ANG; k < S_OUT; k++) begin
				ang_s[k+1] <= ang_s[k];
			end
		end
	end

	for (genvar g = 0; g < D; g++) begin : g_sqrt
		localparam int S = S_SQ0 + g;
		logic [D+2:0] r2, t;
		logic         ge;
		assign r2 = {rem_s[S], rad_s[S][N-1 -: 2]};
		assign t  = {1'b0, root_s[S], 2'b01};
		assign ge = r2 >= t;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[S+1]  <= rad_s[S] << 2;
				rem_s[S+1]  <= ge ? (D+1)'(r2 - t) : (D+1)'(r2);
				root_s[S+1] <= {root_s[S][D-2:0], ge};
			end
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		localparam int S = S_C0 + g;
		localparam logic [63:0] TAB = atan_entry(g);
		logic signed [63:0] ys;
		logic [63:0]        xs;
		assign ys = $signed(cy_s[S]) >>> g;
		assign xs = cx_s[S] >> g;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[S][63]) begin
					cx_s[S+1] <= cx_s[S] + 64'(ys);
					cy_s[S+1] <= cy_s[S] - xs;
					cz_s[S+1] <= cz_s[S] + TAB;
				end else begin
					cx_s[S+1] <= cx_s[S] - 64'(ys);
					cy_s[S+1] <= cy_s[S] + xs;
					cz_s[S+1] <= cz_s[S] - TAB;
				end
			end
		end
	end

`include "planar_distance_and_bearing_core_defines.svh"

	`PDB_ASSERT_NOW(a_coin_zero, m_tvalid && m_tuser[0],
		m_tdata[D+ANGLE_WIDTH-1:0] == '0)
	`PDB_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_s[1])
	`PDB_ASSERT_NEXT(a_stall_holds, vld_s[S_OUT-1] && !en, vld_s[S_OUT-1])

endmodule

// ----- tb/tb_planar_distance_and_bearing_core.sv -----
module tb_planar_distance_and_bearing_core
	import pdb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TDATA_OUT_W = ((DIST_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [63:0] DEG90  = 64'd90 << ANGLE_FRAC_BITS;
	localparam logic [63:0] DEG180 = 64'd180 << ANGLE_FRAC_BITS;
	localparam logic [63:0] DEG270 = 64'd270 << ANGLE_FRAC_BITS;
	localparam logic [63:0] DEG360 = 64'd360 << ANGLE_FRAC_BITS;

	typedef struct {
		logic [DIST_WIDTH-1:0]  distance;
		logic [ANGLE_WIDTH-1:0] angle_deg;
		logic                   coincident;
	} bearing_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [4*COORD_WIDTH-1:0]   s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [TDATA_OUT_W-1:0]     m_tdata;
	logic [0:0]                 m_tuser;

	bearing_t    bearing_q[$];
	logic [63:0] atan_q62[CORDIC_STAGES];
	longint      cycles;
	int          mismatches;
	int          sent;
	int          received;
	bit          no_idle;

	planar_distance_and_bearing_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void fill_atan();
		logic [63:0]  s;
		logic [63:0]  term;
		logic [127:0] prod;
		int           e;
		atan_q62[0] = QT_HALF;
		for (int i = 1; i < CORDIC_STAGES; i++) begin
			s = '0;
			for (int k = 0; k < 64; k++) begin
				e = i * (2 * k + 1);
				if (e > 62) break;
				term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
				if (term == 0) break;
				if (k % 2 == 1) s = s - term;
				else s = s + term;
			end
			prod = 128'(s) * 128'(TWO_OVER_PI_Q64);
			atan_q62[i] = prod[127:64];
		end
	endfunction

	function automatic logic [63:0] octant_bearing(logic [63:0] a, logic [63:0] b);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
		logic [63:0] xs;
		logic [63:0] ys;
		logic [63:0] v;
		x = a;
		y = b;
		z = '0;
		while (x < (64'd1 << 59)) begin
			x = x << 1;
			y = y << 1;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >> i;
			ys = $signed(y) >>> i;
			if (!y[63]) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_q62[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_q62[i];
			end
		end
		if (z[63]) z = '0;
		else if (z > QT_HALF) z = QT_HALF;
		v = (z >> 6) * 64'd90;
		return (v + (64'd1 << (55 - ANGLE_FRAC_BITS))) >> (56 - ANGLE_FRAC_BITS);
	endfunction

	function automatic bearing_t predict_bearing(logic [4*COORD_WIDTH-1:0] pts);
		bearing_t     r;
		longint       dx;
		longint       dy;
		logic [63:0]  ax;
		logic [63:0]  ay;
		logic [127:0] sq;
		logic [127:0] root;
		logic [127:0] trial;
		logic [63:0]  phi;
		logic [63:0]  ang;
		dx = longint'($signed(pts[31:0])) - longint'($signed(pts[95:64]));
		dy = longint'($signed(pts[63:32])) - longint'($signed(pts[127:96]));
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= sq) root = trial;
		end
		r.distance = root[DIST_WIDTH-1:0];
		r.coincident = 1'b0;
		if (dx == 0 && dy == 0) begin
			r.angle_deg = '0;
			r.coincident = 1'b1;
			return r;
		end
		if (dy == 0) begin
			ang = dx > 0 ? 64'd0 : DEG180;
		end else if (dx == 0) begin
			ang = dy > 0 ? DEG90 : DEG270;
		end else begin
			if (ay <= ax) phi = octant_bearing(ax, ay);
			else phi = DEG90 - octant_bearing(ay, ax);
			if (dx > 0 && dy > 0) ang = phi;
			else if (dx < 0 && dy > 0) ang = DEG180 - phi;
			else if (dx < 0) ang = DEG180 + phi;
			else ang = DEG360 - phi;
			if (ang >= DEG360) ang = ang - DEG360;
		end
		r.angle_deg = ang[ANGLE_WIDTH-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, bearing_q.size());
			$display("FAIL planar_distance_and_bearing_core");
			$finish;
		end
	end

	always @(posedge clk) begin
		bearing_t want;
		if (arst_n && m_tvalid && m_tready) begin
			received++;
			if (bearing_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction: %h", m_tdata);
			end else begin
				want = bearing_q.pop_front();
				if (m_tdata[DIST_WIDTH-1:0] !== want.distance ||
				    m_tdata[DIST_WIDTH+ANGLE_WIDTH-1:DIST_WIDTH] !== want.angle_deg ||
				    m_tdata[TDATA_OUT_W-1:DIST_WIDTH+ANGLE_WIDTH] !== '0 ||
				    m_tuser[0] !== want.coincident) begin
					mismatches++;
					if (mismatches <= 10)
						$display("dist %0d/%0d angle %0d/%0d coinc %0b/%0b (exp/got)",
							want.distance, m_tdata[DIST_WIDTH-1:0], want.angle_deg,
							m_tdata[DIST_WIDTH+ANGLE_WIDTH-1:DIST_WIDTH],
							want.coincident, m_tuser[0]);
				end
			end
		end
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, 9);
			m_tready = 1'b0;
			repeat (stall) @(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_points(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx, logic [31:0] sy);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {sy, sx, fy, fx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		bearing_q.insert(bearing_q.size(), predict_bearing(s_tdata));
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (bearing_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [31:0] mx;
		logic [31:0] mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		send_points(0, 0, 0, 0);
		send_points(mx, mn, mx, mn);
		send_points(mx, mx, mn, mn);
		send_points(mn, mn, mx, mx);
		send_points(mx, mn, mn, mx);
		send_points(mn, mx, mx, mn);
		send_points(5, 0, 0, 0);
		send_points(0, 5, 0, 0);
		send_points(-5, 0, 0, 0);
		send_points(0, -5, 0, 0);
		send_points(mx, 0, mn, 0);
		send_points(0, mn, 0, mx);
		send_points(7, 7, 0, 0);
		send_points(-7, 7, 0, 0);
		send_points(-7, -7, 0, 0);
		send_points(7, -7, 0, 0);
		send_points(mx, -1, mn, 0);
		send_points(1, -1, 0, 0);
		send_points(3, 4, 0, 0);
		send_points(mx, 1, mn, 0);
		send_points(1, mx, 0, mn);
		send_points(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
	endtask

	task automatic random_pair(int mode);
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] sx;
		logic [31:0] sy;
		fx = $urandom;
		fy = $urandom;
		case (mode)
			0: begin
				sx = $urandom;
				sy = $urandom;
			end
			1: begin
				sx = fx + $urandom_range(0, 16) - 8;
				sy = fy + $urandom_range(0, 16) - 8;
			end
			2: begin
				sx = fx - ($urandom & 32'h0000_FFFF);
				sy = fy - ($urandom & 32'h0000_FFFF);
			end
			default: begin
				sx = fx + $urandom_range(0, 1000);
				sy = ($urandom_range(0, 1) == 1) ? fy + (fx - sx) : fy - (fx - sx);
			end
		endcase
		send_points(fx, fy, sx, sy);
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
			random_pair($urandom_range(0, 3));
		end
		no_idle = 1'b0;
	endtask

	task automatic test_pause();
		for (int n = 0; n < 40; n++) random_pair($urandom_range(0, 3));
		drain();
		for (int n = 0; n < 40; n++) random_pair($urandom_range(0, 3));
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		cycles = 0;
		mismatches = 0;
		sent = 0;
		received = 0;
		no_idle = 1'b0;
		fill_atan();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_pause();
		test_random(1000);
		drain();
		repeat (60) @(posedge clk);
		$display("covered %0d point pairs (%0d results): axes, diagonals, extremes, coincident",
			sent, received);
		$display("and random pairs with near, diagonal and wide offsets under random stalls");
		if (mismatches == 0 && bearing_q.size() == 0) begin
			$display("PASS planar_distance_and_bearing_core");
		end else begin
			$display("FAIL planar_distance_and_bearing_core");
		end
		$finish;
	end

endmodule
